>>> hw/rtl/mtea_pkg.sv
// ----------------------------------------------------------------------------
// mtea_pkg
// Shared types, constants and round helpers for the masked TEA decryptor.
// ----------------------------------------------------------------------------
package mtea_pkg;

  localparam int unsigned ROUND_COUNT = 32;      // 1 .. 64

  localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;
  localparam logic [31:0] FIRST_MASK  = 32'hA136_B765;
  localparam logic [31:0] SECOND_MASK = 32'hB53E_8492;

  localparam int unsigned CFG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } mtea_blk_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } mtea_key_t;

  // stage handshake toward the next stage
  typedef struct packed {
    logic valid;
  } mtea_fwd_t;

  // TEA mixing term
  function automatic logic [31:0] mix_word(input logic [31:0] w, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
    mix_word = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

  // running sum used in round r (0 = first round); evaluated at elaboration
  function automatic logic [31:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(ROUND_COUNT - r);
    round_sum = prod[31:0];
  endfunction

endpackage

>>> hw/rtl/mtea_whiten.sv
// ----------------------------------------------------------------------------
// mtea_whiten
// Input register stage: XORs both ciphertext words with the fixed masks.
// ----------------------------------------------------------------------------
module mtea_whiten
  import mtea_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  mtea_fwd_t up_fwd,
  input  mtea_blk_t up_blk,
  output logic      up_ready,
  output mtea_fwd_t dn_fwd,
  output mtea_blk_t dn_blk,
  input  logic      dn_ready
);

  logic      vld_r;
  mtea_blk_t blk_r;
  mtea_blk_t blk_nxt;

  assign up_ready = !vld_r || dn_ready;

  always_comb begin
    blk_nxt.first  = up_blk.first  ^ FIRST_MASK;
    blk_nxt.second = up_blk.second ^ SECOND_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_fwd.valid) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_fwd.valid = vld_r;
  assign dn_blk       = blk_r;

endmodule

>>> hw/rtl/mtea_round.sv
// ----------------------------------------------------------------------------
// mtea_round
// One TEA decryption round as two register stages (second word, then first).
// ----------------------------------------------------------------------------
module mtea_round
  import mtea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] sum,
  input  mtea_key_t   key,
  input  mtea_fwd_t   up_fwd,
  input  mtea_blk_t   up_blk,
  output logic        up_ready,
  output mtea_fwd_t   dn_fwd,
  output mtea_blk_t   dn_blk,
  input  logic        dn_ready
);

  logic      h0_vld_r, h1_vld_r;
  mtea_blk_t h0_blk_r, h1_blk_r;
  mtea_blk_t h0_nxt, h1_nxt;
  logic      h0_adv, h1_adv;

  assign h1_adv   = !h1_vld_r || dn_ready;
  assign h0_adv   = !h0_vld_r || h1_adv;
  assign up_ready = h0_adv;

  // second word from first word, keys 2 and 3
  always_comb begin
    h0_nxt.first  = up_blk.first;
    h0_nxt.second = up_blk.second - mix_word(up_blk.first, sum, key.k2, key.k3);
  end

  // first word from the new second word, keys 0 and 1
  always_comb begin
    h1_nxt.second = h0_blk_r.second;
    h1_nxt.first  = h0_blk_r.first - mix_word(h0_blk_r.second, sum, key.k0, key.k1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_vld_r <= 1'b0;
      h1_vld_r <= 1'b0;
    end else begin
      if (h0_adv) begin
        h0_vld_r <= up_fwd.valid;
      end
      if (h1_adv) begin
        h1_vld_r <= h0_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h0_adv && up_fwd.valid) begin
      h0_blk_r <= h0_nxt;
    end
    if (h1_adv && h0_vld_r) begin
      h1_blk_r <= h1_nxt;
    end
  end

  assign dn_fwd.valid = h1_vld_r;
  assign dn_blk       = h1_blk_r;

endmodule

>>> hw/rtl/masked_tea_block_decrypt.sv
// ----------------------------------------------------------------------------
// masked_tea_block_decrypt
// Pipelined TEA block decryptor with fixed input whitening masks.
// ----------------------------------------------------------------------------
// Takes one 64-bit ciphertext block per cycle while in_stall is low, as two
// 32-bit words, XORs them with fixed masks and runs ROUND_COUNT (32) TEA
// decryption rounds, the sum starting at 0xC6EF3720. Throughput is one
// block per clock while out_stall is low. A block passes the whitening
// register and then two register stages per round (one per half-round).
// Each stage holds its own valid bit and moves when empty or when the
// stage after it moves, so bubbles are squeezed out and input transfers
// keep going while a result waits on out_stall until the pipe is full.
// The 128-bit key lives in four cfg registers (index 0..3, higher indexes
// ignored); write them only while no block is in flight.
// ----------------------------------------------------------------------------
module masked_tea_block_decrypt
  import mtea_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            in_cipher_first,
  input  logic [31:0]            in_cipher_second,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_plain_first,
  output logic [31:0]            out_plain_second,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  // key registers
  mtea_key_t key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_WORD0: key_r.k0 <= cfg_data;
        CFG_KEY_WORD1: key_r.k1 <= cfg_data;
        CFG_KEY_WORD2: key_r.k2 <= cfg_data;
        CFG_KEY_WORD3: key_r.k3 <= cfg_data;
        default: ;  // out-of-range index: dropped
      endcase
    end
  end

  // stage links: link 0 is the whitening output, link r+1 is round r output
  mtea_fwd_t fwd  [ROUND_COUNT+1];
  mtea_blk_t blk  [ROUND_COUNT+1];
  logic      rdy  [ROUND_COUNT+1];

  mtea_fwd_t in_fwd;
  mtea_blk_t in_blk;
  logic      in_ready;

  assign in_fwd.valid  = in_valid;
  assign in_blk.first  = in_cipher_first;
  assign in_blk.second = in_cipher_second;
  assign in_stall      = !in_ready;

  mtea_whiten u_whiten (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_fwd   (in_fwd),
    .up_blk   (in_blk),
    .up_ready (in_ready),
    .dn_fwd   (fwd[0]),
    .dn_blk   (blk[0]),
    .dn_ready (rdy[0])
  );

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    localparam logic [31:0] RoundSum = round_sum(r);

    mtea_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .sum      (RoundSum),
      .key      (key_r),
      .up_fwd   (fwd[r]),
      .up_blk   (blk[r]),
      .up_ready (rdy[r]),
      .dn_fwd   (fwd[r+1]),
      .dn_blk   (blk[r+1]),
      .dn_ready (rdy[r+1])
    );
  end

  // last round register doubles as the output register
  assign rdy[ROUND_COUNT] = !out_stall;
  assign out_valid        = fwd[ROUND_COUNT].valid;
  assign out_plain_first  = blk[ROUND_COUNT].first;
  assign out_plain_second = blk[ROUND_COUNT].second;

endmodule

>>> tb/masked_tea_block_decrypt_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_tea_block_decrypt_test
// Self-checking bench for the pipelined masked TEA block decryptor.
// ----------------------------------------------------------------------------
// A clocked driver feeds ciphertext blocks from a pending queue. At each input
// transfer it decrypts the block with the bench's own copy of the key and
// queues the expected plaintext. A clocked monitor compares every output
// transfer field by field with the oldest expected block. Keys change only
// while the pipe is empty. The run steps through several keys, including
// all-zero and all-ones, and writes to unused register indexes. Idle
// patterns vary on both sides, and two long receiver hold-offs fill the
// pipe so that the block stalls its input.
// ----------------------------------------------------------------------------
module masked_tea_block_decrypt_test;
  import mtea_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam int unsigned HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int unsigned PRESSURE_AT_A = 100;     // result counts that start a hold
  localparam int unsigned PRESSURE_AT_B = 330;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic [31:0]            in_cipher_first  = '0;
  logic [31:0]            in_cipher_second = '0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [31:0]            out_plain_first;
  logic [31:0]            out_plain_second;
  logic                   cfg_wr_en        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index        = '0;
  logic [31:0]            cfg_data         = '0;

  // bench copy of the key, indexed like the cfg registers
  logic [31:0] key_words [4] = '{default: '0};

  mtea_blk_t pending_cipher [$];   // blocks waiting to be offered
  mtea_blk_t expected_plain [$];   // plaintext owed by the DUT, oldest first

  int unsigned send_idle_pct = 0;  // chance per cycle that the driver idles
  int unsigned recv_idle_pct = 0;  // chance per cycle that the monitor stalls
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;

  masked_tea_block_decrypt DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cipher_first  (in_cipher_first),
    .in_cipher_second (in_cipher_second),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plain_first  (out_plain_first),
    .out_plain_second (out_plain_second),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // One TEA half-round term; all sums wrap at 32 bits.
  function automatic logic [31:0] feistel_term(input logic [31:0] w, input logic [31:0] s,
                                               input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] shl;
    logic [31:0] shr;
    shl = w << 4;
    shr = w >> 5;
    return (shl + ka) ^ (w + s) ^ (shr + kb);
  endfunction

  // Unmask the ciphertext, then run the rounds backward from delta * rounds.
  function automatic mtea_blk_t decrypt_block(input mtea_blk_t cipher);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    mtea_blk_t   plain;
    a = cipher.first ^ FIRST_MASK;
    b = cipher.second ^ SECOND_MASK;
    s = TEA_DELTA * 32'(ROUND_COUNT);
    for (int r = 0; r < ROUND_COUNT; r++) begin
      b = b - feistel_term(a, s, key_words[2], key_words[3]);
      a = a - feistel_term(b, s, key_words[0], key_words[1]);
      s = s - TEA_DELTA;
    end
    plain.first  = a;
    plain.second = b;
    return plain;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly random words, with zero, all-ones and values that unmask to
  // zero or all-ones mixed in.
  function automatic logic [31:0] pick_word(input logic [31:0] mask);
    case ($urandom_range(11))
      0:       return '0;
      1:       return '1;
      2:       return mask;
      3:       return ~mask;
      default: return $urandom;
    endcase
  endfunction

  function automatic mtea_blk_t random_block();
    mtea_blk_t blk;
    blk.first  = pick_word(FIRST_MASK);
    blk.second = pick_word(SECOND_MASK);
    return blk;
  endfunction

  function automatic void queue_block(input logic [31:0] first, input logic [31:0] second);
    mtea_blk_t blk;
    blk.first  = first;
    blk.second = second;
    pending_cipher.push_back(blk);
  endfunction

  // Hand-picked corners: extremes, blocks that unmask to zero or all-ones,
  // and single-bit words at both ends, then one random block.
  function automatic void queue_directed();
    queue_block('0, '0);
    queue_block('1, '1);
    queue_block(FIRST_MASK, SECOND_MASK);
    queue_block(~FIRST_MASK, ~SECOND_MASK);
    queue_block('0, '1);
    queue_block('1, '0);
    queue_block(32'h8000_0000, 32'h0000_0001);
    queue_block(32'h0000_0001, 32'h8000_0000);
    queue_block(FIRST_MASK, ~SECOND_MASK);
    queue_block($urandom, $urandom);
  endfunction

  function automatic void queue_random(input int unsigned count);
    repeat (count) pending_cipher.push_back(random_block());
  endfunction

  // Writes go back to back; the caller closes the burst with end_cfg.
  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    // indexes past the last key word are ignored by the DUT
    if (idx <= CFG_KEY_WORD3)
      key_words[idx[1:0]] = val;
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    write_cfg(CFG_KEY_WORD0, k0);
    write_cfg(CFG_KEY_WORD1, k1);
    write_cfg(CFG_KEY_WORD2, k2);
    write_cfg(CFG_KEY_WORD3, k3);
    end_cfg();
  endtask

  // Every block yields one result, so an empty scoreboard with nothing
  // queued or offered means the pipe is empty.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending_cipher.size() != 0 || in_valid || expected_plain.size() != 0);
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents pending blocks, holding each one until its transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    mtea_blk_t blk;
    if (in_valid && !in_stall) begin
      blk.first  = in_cipher_first;
      blk.second = in_cipher_second;
      expected_plain.push_back(decrypt_block(blk));
    end
    // a stalled payload stays put; otherwise offer the next block or idle
    if (!in_valid || !in_stall) begin
      if (pending_cipher.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        blk = pending_cipher.pop_front();
        in_valid         <= 1'b1;
        in_cipher_first  <= blk.first;
        in_cipher_second <= blk.second;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each output transfer and drives out_stall.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  int unsigned last_hold_mark = 0;

  always @(posedge clk) begin : monitor
    mtea_blk_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_plain.size() == 0) begin
        $display("%0t: unexpected result first=%h second=%h",
                 $time, out_plain_first, out_plain_second);
        error_count++;
      end else begin
        want = expected_plain.pop_front();
        if (out_plain_first !== want.first) begin
          $display("%0t: plain_first mismatch expected=%h actual=%h",
                   $time, want.first, out_plain_first);
          error_count++;
        end
        if (out_plain_second !== want.second) begin
          $display("%0t: plain_second mismatch expected=%h actual=%h",
                   $time, want.second, out_plain_second);
          error_count++;
        end
      end
      results_seen++;
    end
    // long hold-off at fixed points so the pipe fills and in_stall rises
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((results_seen == PRESSURE_AT_A || results_seen == PRESSURE_AT_B) &&
                 last_hold_mark != results_seen) begin
      last_hold_mark = results_seen;
      hold_left      = HOLD_CYCLES - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("masked_tea_block_decrypt_test: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corners under the reset key (all zero)
    set_idle(26, 59);
    @(negedge clk);
    queue_directed();
    wait_drained();

    // corners under an all-ones key
    load_key('1, '1, '1, '1);
    @(negedge clk);
    queue_directed();
    wait_drained();

    // random key, sender sparse / receiver busy, first long hold-off
    load_key($urandom, $urandom, $urandom, $urandom);
    @(negedge clk);
    queue_random(200);
    wait_drained();

    // unused indexes must leave the key alone; then mixed-extreme key,
    // roles swapped, second hold-off
    write_cfg(CFG_INDEX_W'($urandom_range(2**CFG_INDEX_W - 1, int'(CFG_KEY_WORD3) + 1)), '1);
    write_cfg(CFG_INDEX_W'(2**CFG_INDEX_W - 1), $urandom);
    end_cfg();
    load_key('0, '1, $urandom, $urandom);
    set_idle(59, 26);
    @(negedge clk);
    queue_random(200);
    wait_drained();

    // full rate on both sides
    load_key('1, '0, $urandom, '0);
    set_idle(0, 0);
    @(negedge clk);
    queue_random(150);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("masked_tea_block_decrypt_test: done, clean");
    else
      $display("masked_tea_block_decrypt_test: done, errors");
    $finish;
  end

endmodule
